[hdl/rthh_pkg.sv]
// ----------------------------------------------------------------------------
// rthh_pkg
// Shared types and constants for the RGB to HSV/HSL converter.
// ----------------------------------------------------------------------------
package rthh_pkg;

    localparam int COMP_W     = 8;
    localparam int HUE_W      = 13;
    localparam int SAT_W      = 8;
    localparam int HUE_Q_W    = 11;
    localparam int HUE_N_W    = HUE_Q_W + COMP_W;
    localparam int SAT_Q_W    = 8;
    localparam int SAT_N_W    = SAT_Q_W + COMP_W;
    localparam int DIV_STAGES = HUE_Q_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic REG_IDX_COLOR_MODE = 1'b0;

    localparam logic [HUE_W-1:0] HUE_FULL      = 13'd5760;
    localparam logic [HUE_W-1:0] HUE_OFS_RED   = 13'd4800;
    localparam logic [HUE_W-1:0] HUE_OFS_GREEN = 13'd960;
    localparam logic [HUE_W-1:0] HUE_OFS_BLUE  = 13'd2880;

    typedef enum logic
    {
        MODE_HSV = 1'b0,
        MODE_HSL = 1'b1
    } mode_t;

    typedef enum logic [1:0]
    {
        SECTOR_RED,
        SECTOR_GREEN,
        SECTOR_BLUE
    } sector_t;

    // after max/min selection
    typedef struct packed
    {
        logic [COMP_W-1:0] maxv;
        logic [COMP_W-1:0] minv;
        logic [COMP_W-1:0] pa;
        logic [COMP_W-1:0] pb;
        sector_t           sector;
        mode_t             mode;
    } front_t;

    // state carried through the divider pipeline
    typedef struct packed
    {
        sector_t            sector;
        logic               achromatic;
        logic [COMP_W-1:0]  level;
        logic [COMP_W-1:0]  hue_rem;
        logic [HUE_Q_W-1:0] hue_low;
        logic [HUE_Q_W-1:0] hue_quo;
        logic [COMP_W-1:0]  hue_den;
        logic [COMP_W-1:0]  sat_rem;
        logic [SAT_Q_W-1:0] sat_low;
        logic [SAT_Q_W-1:0] sat_quo;
        logic [COMP_W-1:0]  sat_den;
    } div_t;

endpackage

[hdl/rthh_pix_if.sv]
// ----------------------------------------------------------------------------
// rthh_pix_if
// Pixel input channel: valid/ready handshake with RGB payload.
// ----------------------------------------------------------------------------
interface rthh_pix_if import rthh_pkg::*; ();

    logic              valid;
    logic              ready;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);

endinterface

[hdl/rthh_hsx_if.sv]
// ----------------------------------------------------------------------------
// rthh_hsx_if
// Result channel: valid/ready handshake with hue, saturation, level, grey flag.
// ----------------------------------------------------------------------------
interface rthh_hsx_if import rthh_pkg::*; ();

    logic             valid;
    logic             ready;
    logic [HUE_W-1:0] hue;
    logic [SAT_W-1:0] saturation;
    logic [COMP_W-1:0] level;
    logic             achromatic;

    modport source (output valid, hue, saturation, level, achromatic, input ready);
    modport sink   (input valid, hue, saturation, level, achromatic, output ready);

endinterface

[hdl/rthh_front.sv]
// ----------------------------------------------------------------------------
// rthh_front
// Two pipeline stages: max/min and sector selection, then delta, hue and
// saturation numerators, divisors and level.
// ----------------------------------------------------------------------------
module rthh_front import rthh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [COMP_W-1:0] red,
    input  logic [COMP_W-1:0] green,
    input  logic [COMP_W-1:0] blue,
    input  mode_t             mode,
    output logic              out_valid,
    input  logic              out_ready,
    output div_t              out_data
);

    logic   a_valid_reg;
    front_t a_reg;
    front_t a_next;
    logic   a_ready;

    logic   b_valid_reg;
    div_t   b_reg;
    div_t   b_next;

    // stage A: sector and extremes (first max in red, green, blue order)
    always_comb
    begin
        a_next      = '0;
        a_next.mode = mode;
        if (red >= green && red >= blue)
        begin
            a_next.sector = SECTOR_RED;
            a_next.maxv   = red;
            a_next.pa     = green;
            a_next.pb     = blue;
        end
        else if (green >= blue)
        begin
            a_next.sector = SECTOR_GREEN;
            a_next.maxv   = green;
            a_next.pa     = blue;
            a_next.pb     = red;
        end
        else
        begin
            a_next.sector = SECTOR_BLUE;
            a_next.maxv   = blue;
            a_next.pa     = red;
            a_next.pb     = green;
        end
        if (red <= green && red <= blue)
        begin
            a_next.minv = red;
        end
        else if (green <= blue)
        begin
            a_next.minv = green;
        end
        else
        begin
            a_next.minv = blue;
        end
    end

    assign a_ready  = !b_valid_reg || out_ready;
    assign in_ready = !a_valid_reg || a_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_reg <= a_next;
        end
    end

    // stage B: numerators and divisors
    always_comb
    begin
        logic [COMP_W-1:0]  delta;
        logic [COMP_W:0]    t;
        logic [COMP_W:0]    sum;
        logic [COMP_W:0]    spread;
        logic [COMP_W-1:0]  den_hsl;
        logic [HUE_N_W-1:0] hue_num;
        logic [SAT_N_W-1:0] sat_num;

        delta   = a_reg.maxv - a_reg.minv;
        // pa - pb + delta lies in 0..2*delta
        t       = {1'b0, a_reg.pa} - {1'b0, a_reg.pb} + {1'b0, delta};
        // 960 * t
        hue_num = {t, 10'b0} - {4'b0, t, 6'b0};
        // 255 * delta
        sat_num = {delta, 8'b0} - {8'b0, delta};
        sum     = {1'b0, a_reg.maxv} + {1'b0, a_reg.minv};
        spread  = (sum > 9'd255) ? (sum - 9'd255) : (9'd255 - sum);
        den_hsl = 8'd255 - spread[COMP_W-1:0];

        b_next            = '0;
        b_next.sector     = a_reg.sector;
        b_next.achromatic = (delta == '0);
        b_next.level      = (a_reg.mode == MODE_HSL) ? sum[COMP_W:1] : a_reg.maxv;
        b_next.hue_rem    = hue_num[HUE_N_W-1:HUE_Q_W];
        b_next.hue_low    = hue_num[HUE_Q_W-1:0];
        b_next.hue_den    = delta;
        b_next.sat_rem    = sat_num[SAT_N_W-1:SAT_Q_W];
        b_next.sat_low    = sat_num[SAT_Q_W-1:0];
        b_next.sat_den    = (a_reg.mode == MODE_HSL) ? den_hsl : a_reg.maxv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_ready)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && a_valid_reg)
        begin
            b_reg <= b_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_reg;

endmodule

[hdl/rthh_div_stage.sv]
// ----------------------------------------------------------------------------
// rthh_div_stage
// One restoring division step for hue and saturation (saturation only while
// STEP < SAT_Q_W), one quotient bit each, with its own pipeline register.
// ----------------------------------------------------------------------------
module rthh_div_stage import rthh_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  div_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output div_t out_data
);

    localparam logic SAT_ACTIVE = (STEP < SAT_Q_W);

    logic valid_reg;
    div_t data_reg;
    div_t data_next;

    always_comb
    begin
        logic [COMP_W:0] hue_trial;
        logic [COMP_W:0] sat_trial;
        logic            hue_bit;
        logic            sat_bit;

        data_next = in_data;

        hue_trial = {in_data.hue_rem, in_data.hue_low[HUE_Q_W-1]};
        hue_bit   = (hue_trial >= {1'b0, in_data.hue_den});
        if (hue_bit)
        begin
            hue_trial = hue_trial - {1'b0, in_data.hue_den};
        end
        data_next.hue_rem = hue_trial[COMP_W-1:0];
        data_next.hue_low = {in_data.hue_low[HUE_Q_W-2:0], 1'b0};
        data_next.hue_quo = {in_data.hue_quo[HUE_Q_W-2:0], hue_bit};

        sat_trial = {in_data.sat_rem, in_data.sat_low[SAT_Q_W-1]};
        sat_bit   = (sat_trial >= {1'b0, in_data.sat_den});
        if (sat_bit)
        begin
            sat_trial = sat_trial - {1'b0, in_data.sat_den};
        end
        if (SAT_ACTIVE)
        begin
            data_next.sat_rem = sat_trial[COMP_W-1:0];
            data_next.sat_low = {in_data.sat_low[SAT_Q_W-2:0], 1'b0};
            data_next.sat_quo = {in_data.sat_quo[SAT_Q_W-2:0], sat_bit};
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[hdl/rthh_back.sv]
// ----------------------------------------------------------------------------
// rthh_back
// Output stage: adds the sector offset to the hue quotient, wraps a full
// circle, clears grey pixels and holds the result register.
// ----------------------------------------------------------------------------
module rthh_back import rthh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  div_t              in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [HUE_W-1:0]  hue,
    output logic [SAT_W-1:0]  saturation,
    output logic [COMP_W-1:0] level,
    output logic              achromatic
);

    logic              valid_reg;
    logic [HUE_W-1:0]  hue_reg;
    logic [HUE_W-1:0]  hue_next;
    logic [SAT_W-1:0]  sat_reg;
    logic [SAT_W-1:0]  sat_next;
    logic [COMP_W-1:0] level_reg;
    logic              achromatic_reg;

    always_comb
    begin
        logic [HUE_W-1:0] offset;
        logic [HUE_W-1:0] raw;

        case (in_data.sector)
            SECTOR_RED:   offset = HUE_OFS_RED;
            SECTOR_GREEN: offset = HUE_OFS_GREEN;
            SECTOR_BLUE:  offset = HUE_OFS_BLUE;
            default:      offset = '0;
        endcase
        raw = offset + {{(HUE_W-HUE_Q_W){1'b0}}, in_data.hue_quo};
        if (raw >= HUE_FULL)
        begin
            raw = raw - HUE_FULL;
        end
        hue_next = in_data.achromatic ? '0 : raw;
        sat_next = in_data.achromatic ? '0 : in_data.sat_quo;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hue_reg        <= hue_next;
            sat_reg        <= sat_next;
            level_reg      <= in_data.level;
            achromatic_reg <= in_data.achromatic;
        end
    end

    assign out_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign level      = level_reg;
    assign achromatic = achromatic_reg;

endmodule

[hdl/rgb_to_hsv_hsl.sv]
// ----------------------------------------------------------------------------
// rgb_to_hsv_hsl
// RGB pixel to hue / saturation / value-or-lightness converter.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one result per clock, in order, while
// the output is not stalled. The pipeline has two front stages (max/min, then
// numerators and divisors), eleven restoring division stages that each resolve
// one hue quotient bit (the first eight also one saturation bit), and one
// output stage. Each stage holds its transaction until the next stage has
// room, so stalls on the output fill bubbles before backing up to the input.
// color_mode (register 0, bit 0) selects HSV (0) or HSL (1) and is sampled as
// a pixel enters; write it only while idle.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hsl import rthh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    rthh_pix_if.sink          pix,
    rthh_hsx_if.source        hsx,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    mode_t color_mode_reg;
    logic  cfg_write;

    logic  stg_valid [DIV_STAGES+1];
    logic  stg_ready [DIV_STAGES+1];
    div_t  stg_data  [DIV_STAGES+1];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= MODE_HSV;
        end
        else if (cfg_write && paddr[APB_AW-1] == REG_IDX_COLOR_MODE)
        begin
            color_mode_reg <= mode_t'(pwdata[0]);
        end
    end

    assign prdata = (paddr[APB_AW-1] == REG_IDX_COLOR_MODE)
                  ? {{(APB_DW-1){1'b0}}, color_mode_reg}
                  : '0;

    rthh_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix.valid),
        .in_ready  (pix.ready),
        .red       (pix.red),
        .green     (pix.green),
        .blue      (pix.blue),
        .mode      (color_mode_reg),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar i = 0; i < DIV_STAGES; i++)
    begin : g_div
        rthh_div_stage #(.STEP(i)) u_div_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    rthh_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stg_valid[DIV_STAGES]),
        .in_ready   (stg_ready[DIV_STAGES]),
        .in_data    (stg_data[DIV_STAGES]),
        .out_valid  (hsx.valid),
        .out_ready  (hsx.ready),
        .hue        (hsx.hue),
        .saturation (hsx.saturation),
        .level      (hsx.level),
        .achromatic (hsx.achromatic)
    );

endmodule

[hdl/rthh_checker.sv]
// ----------------------------------------------------------------------------
// rthh_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
module rthh_checker import rthh_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [HUE_W-1:0]  hue,
    input logic [SAT_W-1:0]  saturation,
    input logic [COMP_W-1:0] level,
    input logic              achromatic,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [APB_DW-1:0] pwdata,
    input logic [APB_DW-1:0] prdata,
    input logic              pready
);

    // hue stays below a full circle
    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hue < HUE_FULL)
        else $error("hue out of range");

    // grey pixels carry no hue or saturation
    a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && achromatic) |-> (hue == '0 && saturation == '0))
        else $error("grey pixel with nonzero hue or saturation");

    // mode register write shows on readback
    a_mode_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && paddr[APB_AW-1] == REG_IDX_COLOR_MODE)
        |=> (paddr[APB_AW-1] != REG_IDX_COLOR_MODE || prdata[0] == $past(pwdata[0])))
        else $error("color_mode readback mismatch");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(hue) && $stable(saturation) && $stable(level)
         && $stable(achromatic)))
        else $error("result changed while stalled");

endmodule

bind rgb_to_hsv_hsl rthh_checker u_rthh_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (hsx.valid),
    .out_ready  (hsx.ready),
    .hue        (hsx.hue),
    .saturation (hsx.saturation),
    .level      (hsx.level),
    .achromatic (hsx.achromatic),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
);
